[hw/rtl/psd_pkg.sv]
// shared types and constants for the prufer sequence decoder
`default_nettype none

package psd_pkg;

   // width of a vertex number on the ports
   localparam int VERTEX_W = 7;

   // one input item: a parent vertex, the last one of a sequence marked
   typedef struct packed {
      logic [VERTEX_W-1:0] parent_vertex;
      logic                last_cut;
   } cut_req_type;

   // one result item: a removed leaf, or the error result
   typedef struct packed {
      logic [VERTEX_W-1:0] cut_leaf;
      logic                decode_error;
      logic                last_result;
   } cut_rsp_type;

   // classified item passed from the front to the back through the queue
   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic                seq_end;
      logic                range_bad;
   } cut_entry_type;

endpackage

`default_nettype wire

[hw/rtl/prufer_sequence_decoder.sv]
// top level of the prufer sequence decoder: front, queue and back
// loading takes one cycle per item once the back is waiting for items
// a sequence is then checked, decoded and delivered: the degree store is
// touched in three step read-modify-write sequences, and each leaf goes out
// through the leaf buffer
// a synchronous reset empties the queue and returns the back to loading
`default_nettype none

module prufer_sequence_decoder #(
   parameter int MAX_CUTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire psd_pkg::cut_req_type  req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output psd_pkg::cut_rsp_type       rsp_data
);

   logic                   f_valid;
   logic                   f_ready;
   psd_pkg::cut_entry_type f_entry;
   logic                   q_valid;
   logic                   q_ready;
   psd_pkg::cut_entry_type q_entry;

   psd_front #(.MAX_CUTS(MAX_CUTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (f_valid),
      .q_ready   (f_ready),
      .q_entry   (f_entry)
   );

   psd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_entry  (f_entry),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_entry (q_entry)
   );

   psd_back #(.MAX_CUTS(MAX_CUTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_entry   (q_entry),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // an error result is the only result of its sequence and carries no leaf
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.decode_error |->
         rsp_data.last_result && (rsp_data.cut_leaf == '0))
      else $error("error result not marked last or carries a leaf");

   // inputs are held off only while the queue holds items
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> q_valid)
      else $error("input stalled with an empty queue");

   // a queued item leaves the queue only when the back takes it
   assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> q_valid)
      else $error("queued item lost");

endmodule

`default_nettype wire

[hw/rtl/psd_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module psd_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [ADDR_W-1:0]        wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [ADDR_W-1:0]        rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/psd_front.sv]
// front part: counts sequence positions and classifies each incoming item
`default_nettype none

module psd_front #(
   parameter int MAX_CUTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire psd_pkg::cut_req_type  req_data,
   output logic                       q_valid,
   input  wire logic                  q_ready,
   output psd_pkg::cut_entry_type     q_entry
);

   localparam int IDX_W = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;
   localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(MAX_CUTS - 1);
   localparam logic [psd_pkg::VERTEX_W-1:0] VTX_MAX = psd_pkg::VERTEX_W'(MAX_CUTS + 1);

   logic [IDX_W-1:0] count_ff;
   logic [IDX_W-1:0] count_in;
   logic             at_end;
   logic             accept;

   // a sequence ends on a marked item or when the store fills
   assign at_end = req_data.last_cut || (count_ff == IDX_FULL);
   assign accept = req_valid && q_ready;

   assign q_valid            = req_valid;
   assign req_ready          = q_ready;
   assign q_entry.vertex     = req_data.parent_vertex;
   assign q_entry.seq_end    = at_end;
   assign q_entry.range_bad  = (req_data.parent_vertex == '0) ||
                               (req_data.parent_vertex > VTX_MAX);

   // position counter
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = at_end ? '0 : count_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/psd_queue.sv]
// two entry queue between the front and the back
`default_nettype none

module psd_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   output logic                         in_ready,
   input  wire psd_pkg::cut_entry_type  in_entry,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output psd_pkg::cut_entry_type       out_entry
);

   psd_pkg::cut_entry_type entries_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic       push;
   logic       pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_entry = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_entry;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

`default_nettype wire

[hw/rtl/psd_back.sv]
// back part: stores a sequence, decodes it and delivers the results
`default_nettype none

module psd_back #(
   parameter int MAX_CUTS = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   output logic                         q_ready,
   input  wire psd_pkg::cut_entry_type  q_entry,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output psd_pkg::cut_rsp_type         rsp_data
);

   localparam int VW    = psd_pkg::VERTEX_W;
   localparam int IDX_W = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;
   localparam int CNT_W = $clog2(MAX_CUTS + 1);
   localparam int NV    = MAX_CUTS + 2;
   localparam int VI_W  = $clog2(NV);

   // sequencer states
   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_CHECK = 4'd1;
   localparam logic [3:0] S_CLEAR = 4'd2;
   localparam logic [3:0] S_COUNT = 4'd3;
   localparam logic [3:0] S_INIT  = 4'd4;
   localparam logic [3:0] S_STEP  = 4'd5;
   localparam logic [3:0] S_FINAL = 4'd6;
   localparam logic [3:0] S_EMIT  = 4'd7;
   localparam logic [3:0] S_ERROR = 4'd8;

   // sub-steps of one element
   localparam logic [1:0] PH_ADDR = 2'd0;
   localparam logic [1:0] PH_SEQ  = 2'd1;
   localparam logic [1:0] PH_CNT  = 2'd2;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] num_ff, num_in;
   logic [VI_W-1:0]  ptr_ff, ptr_in;
   logic             fault_ff, fault_in;
   logic [VW-1:0]    max_ff, max_in;
   logic [NV-1:0]    ready_ff, ready_in;
   psd_pkg::cut_rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [VW-1:0]    top;
   logic [VI_W-1:0]  top_idx;
   logic [IDX_W-1:0] idx_last;
   logic             rsp_free;
   logic [NV-1:0]    final_expect;
   logic [VI_W-1:0]  leaf;
   logic             leaf_found;

   logic             seq_we;
   logic [VW-1:0]    seq_rd_data;
   logic             cnt_we;
   logic [VI_W-1:0]  cnt_wa;
   logic [CNT_W-1:0] cnt_wd;
   logic [VI_W-1:0]  cnt_ra;
   logic [CNT_W-1:0] cnt_rd_data;
   logic [CNT_W-1:0] cnt_dec;
   logic             leaf_we;
   logic [VW-1:0]    leaf_rd_data;
   logic [VI_W-1:0]  seq_vtx;

   assign top      = VW'(num_ff) + VW'(1);
   assign top_idx  = VI_W'(top);
   assign idx_last = IDX_W'(num_ff - CNT_W'(1));
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign q_ready  = (state_ff == S_LOAD);
   assign seq_vtx  = VI_W'(seq_rd_data);
   assign cnt_dec  = cnt_rd_data - CNT_W'(1);

   // smallest pending leaf
   always_comb begin
      leaf       = '0;
      leaf_found = 1'b0;
      for (int k = NV - 1; k >= 1; k--) begin
         if (ready_ff[k]) begin
            leaf       = VI_W'(k);
            leaf_found = 1'b1;
         end
      end
   end

   // a valid decode leaves only the top vertex pending
   always_comb begin
      for (int k = 0; k < NV; k++) begin
         final_expect[k] = (VI_W'(k) == top_idx);
      end
   end

   // sequence store, written while loading and read by element index
   assign seq_we = q_valid && q_ready;

   psd_ram #(.WIDTH(VW), .DEPTH(MAX_CUTS)) u_seq_ram (
      .clock   (clock),
      .wr_en   (seq_we),
      .wr_addr (idx_ff),
      .wr_data (q_entry.vertex),
      .rd_addr (idx_ff),
      .rd_data (seq_rd_data)
   );

   // degree store holds the number of remaining appearances of each vertex
   always_comb begin
      cnt_we = 1'b0;
      cnt_wa = seq_vtx;
      cnt_wd = cnt_rd_data + CNT_W'(1);
      if (state_ff == S_CLEAR) begin
         cnt_we = 1'b1;
         cnt_wa = ptr_ff;
         cnt_wd = '0;
      end else if (state_ff == S_COUNT && phase_ff == PH_CNT) begin
         cnt_we = 1'b1;
      end else if (state_ff == S_STEP && phase_ff == PH_CNT) begin
         cnt_we = 1'b1;
         cnt_wd = cnt_dec;
      end
   end

   // seq data holds the current element's vertex in the later sub-steps
   assign cnt_ra = (state_ff == S_INIT) ? ptr_ff : seq_vtx;

   psd_ram #(.WIDTH(CNT_W), .DEPTH(NV)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wa),
      .wr_data (cnt_wd),
      .rd_addr (cnt_ra),
      .rd_data (cnt_rd_data)
   );

   // leaf buffer holds the decoded leaves until the decode is known good
   assign leaf_we = (state_ff == S_STEP) && (phase_ff == PH_ADDR) && leaf_found;

   psd_ram #(.WIDTH(VW), .DEPTH(MAX_CUTS)) u_leaf_ram (
      .clock   (clock),
      .wr_en   (leaf_we),
      .wr_addr (idx_ff),
      .wr_data (VW'(leaf)),
      .rd_addr (idx_ff),
      .rd_data (leaf_rd_data)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      num_in       = num_ff;
      ptr_in       = ptr_ff;
      fault_in     = fault_ff;
      max_in       = max_ff;
      ready_in     = ready_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_LOAD: begin
            if (q_valid) begin
               fault_in = fault_ff || q_entry.range_bad;
               if (q_entry.vertex > max_ff) begin
                  max_in = q_entry.vertex;
               end
               if (q_entry.seq_end) begin
                  num_in   = CNT_W'(idx_ff) + CNT_W'(1);
                  state_in = S_CHECK;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_CHECK: begin
            if (fault_ff || (max_ff > top)) begin
               state_in = S_ERROR;
            end else begin
               ptr_in   = VI_W'(1);
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            if (ptr_ff == top_idx) begin
               idx_in   = '0;
               phase_in = PH_ADDR;
               state_in = S_COUNT;
            end else begin
               ptr_in = ptr_ff + VI_W'(1);
            end
         end
         S_COUNT: begin
            if (phase_ff == PH_ADDR) begin
               phase_in = PH_SEQ;
            end else if (phase_ff == PH_SEQ) begin
               phase_in = PH_CNT;
            end else begin
               phase_in = PH_ADDR;
               if (idx_ff == idx_last) begin
                  ptr_in   = VI_W'(1);
                  state_in = S_INIT;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_INIT: begin
            if (phase_ff == PH_ADDR) begin
               phase_in = PH_SEQ;
            end else begin
               phase_in = PH_ADDR;
               if (cnt_rd_data == '0) begin
                  ready_in[ptr_ff] = 1'b1;
               end
               if (ptr_ff == top_idx) begin
                  idx_in   = '0;
                  state_in = S_STEP;
               end else begin
                  ptr_in = ptr_ff + VI_W'(1);
               end
            end
         end
         S_STEP: begin
            if (phase_ff == PH_ADDR) begin
               if (leaf_found) begin
                  ready_in[leaf] = 1'b0;
                  phase_in       = PH_SEQ;
               end else begin
                  state_in = S_ERROR;
               end
            end else if (phase_ff == PH_SEQ) begin
               phase_in = PH_CNT;
            end else begin
               phase_in = PH_ADDR;
               if (cnt_dec == '0 && !ready_ff[seq_vtx]) begin
                  ready_in[seq_vtx] = 1'b1;
               end
               if (idx_ff == idx_last) begin
                  state_in = S_FINAL;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_FINAL: begin
            if (ready_ff == final_expect) begin
               idx_in   = '0;
               phase_in = PH_ADDR;
               state_in = S_EMIT;
            end else begin
               state_in = S_ERROR;
            end
         end
         S_EMIT: begin
            if (phase_ff == PH_ADDR) begin
               phase_in = PH_SEQ;
            end else if (rsp_free) begin
               rsp_in.cut_leaf     = leaf_rd_data;
               rsp_in.decode_error = 1'b0;
               rsp_in.last_result  = (idx_ff == idx_last);
               rsp_valid_in        = 1'b1;
               phase_in            = PH_ADDR;
               if (idx_ff == idx_last) begin
                  state_in = S_LOAD;
                  idx_in   = '0;
                  fault_in = 1'b0;
                  max_in   = '0;
                  ready_in = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_ERROR: begin
            if (rsp_free) begin
               rsp_in.cut_leaf     = '0;
               rsp_in.decode_error = 1'b1;
               rsp_in.last_result  = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = S_LOAD;
               phase_in            = PH_ADDR;
               idx_in              = '0;
               fault_in            = 1'b0;
               max_in              = '0;
               ready_in            = '0;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         phase_ff     <= PH_ADDR;
         idx_ff       <= '0;
         num_ff       <= '0;
         ptr_ff       <= '0;
         fault_ff     <= 1'b0;
         max_ff       <= '0;
         ready_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         num_ff       <= num_in;
         ptr_ff       <= ptr_in;
         fault_ff     <= fault_in;
         max_ff       <= max_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
